FILE: hdl/dge_pkg.sv
// ---------------------------------------------------------------------------
// dge_pkg
// Shared constants, types and helpers for the disc dilate / erode block.
// ---------------------------------------------------------------------------
package dge_pkg;

    localparam int TILE_SIZE   = 64;
    localparam int MAX_RADIUS  = 64;
    localparam int STORE_W     = TILE_SIZE + 2 * MAX_RADIUS;
    localparam int STORE_H     = 2 * MAX_RADIUS + 1;
    localparam int STORE_DEPTH = STORE_W * STORE_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_W);
    localparam int RAD_W       = 7;
    localparam int PIX_W       = 16;
    localparam int BOUND_W     = 2 * RAD_W;
    localparam int REG_IDX_W   = 1;

    localparam logic [PIX_W-1:0]     ALPHA_ONE  = PIX_W'(32768);
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MODE   = REG_IDX_W'(1);

    // One output pixel waiting for its window scan
    typedef struct packed {
        logic [POS_W-1:0] col_base;
        logic [POS_W-1:0] slot;
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACC
    } t_back_state;

    // Row store address of a slot and a column
    function automatic logic [ADDR_W-1:0] f_addr(input logic [POS_W-1:0] slot,
                                                 input logic [POS_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base   = ADDR_W'(slot) * ADDR_W'(STORE_W);
        f_addr = base + ADDR_W'(col);
    endfunction

endpackage

FILE: hdl/dge_ram.sv
// ---------------------------------------------------------------------------
// dge_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/dge_front.sv
// ---------------------------------------------------------------------------
// dge_front
// Accept padded pixels, store them in the row store and queue window jobs.
// ---------------------------------------------------------------------------
module dge_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [dge_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_stall,
    input  logic                      i_restart,
    input  logic [dge_pkg::RAD_W-1:0] i_radius,
    output logic                      o_full,
    output logic                      o_job_push,
    output dge_pkg::t_job             o_job,
    output logic                      o_mem_we,
    output logic [dge_pkg::ADDR_W-1:0] o_mem_addr,
    output logic [dge_pkg::PIX_W-1:0] o_mem_wdata
);
    import dge_pkg::*;

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_wslot, n_wslot;
    logic [POS_W-1:0] two_r;
    logic [POS_W-1:0] w_last;
    logic             accept;

    assign two_r  = {i_radius, 1'b0};
    assign w_last = POS_W'(TILE_SIZE - 1) + two_r;
    assign accept = i_push && !i_stall;
    assign o_full = i_stall;

    // Store the pixel and classify it
    assign o_mem_we    = accept;
    assign o_mem_addr  = f_addr(r_wslot, r_col);
    assign o_mem_wdata = i_pixel;
    assign o_job_push  = accept && (r_row >= two_r) && (r_col >= two_r);
    assign o_job.col_base = r_col - two_r;
    assign o_job.slot     = (r_wslot == two_r) ? '0 : r_wslot + POS_W'(1);
    assign o_job.last     = (r_row == w_last) && (r_col == w_last);

    // Advance the padded position
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_wslot = r_wslot;
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_wslot = '0;
        end else if (accept) begin
            if (r_col == w_last) begin
                n_col = '0;
                if (r_row == w_last) begin
                    n_row   = '0;
                    n_wslot = '0;
                end else begin
                    n_row   = r_row + POS_W'(1);
                    n_wslot = (r_wslot == two_r) ? '0 : r_wslot + POS_W'(1);
                end
            end else begin
                n_col = r_col + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_wslot <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_wslot <= n_wslot;
        end
    end

endmodule

FILE: hdl/dge_job_q.sv
// ---------------------------------------------------------------------------
// dge_job_q
// Two-entry queue of window jobs between the front and the back.
// ---------------------------------------------------------------------------
module dge_job_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dge_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output dge_pkg::t_job o_job
);
    import dge_pkg::*;

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_ent[r_rp];

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: hdl/dge_back.sv
// ---------------------------------------------------------------------------
// dge_back
// Scan the disc window of one job through the row store, keep the extreme.
// ---------------------------------------------------------------------------
module dge_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  dge_pkg::t_job               i_job,
    input  logic [dge_pkg::RAD_W-1:0]   i_radius,
    input  logic                        i_mode,
    input  logic [dge_pkg::BOUND_W-1:0] i_bound,
    input  logic [dge_pkg::PIX_W-1:0]   i_rdata,
    input  logic                        i_pop,
    output logic                        o_job_pop,
    output logic                        o_busy,
    output logic                        o_rd_en,
    output logic [dge_pkg::ADDR_W-1:0]  o_rd_addr,
    output logic                        o_empty,
    output logic [dge_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                        o_tile_done
);
    import dge_pkg::*;

    t_back_state      r_state, n_state;
    logic [POS_W-1:0] r_c, n_c;
    logic [POS_W-1:0] r_dxi, n_dxi;
    logic [POS_W-1:0] r_slot, n_slot;
    logic [POS_W-1:0] r_colb, n_colb;
    logic             r_last, n_last;
    logic [PIX_W-1:0] r_ext, n_ext;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pix, n_out_pix;
    logic             r_out_last, n_out_last;

    logic [POS_W-1:0]   two_r, rz, dx_full, dy_full;
    logic [BOUND_W-1:0] dx2, dy2;
    logic [BOUND_W:0]   dsum;
    logic               in_disc;
    logic [PIX_W-1:0]   ext_acc, ext_cur, lim;
    logic               row_end, win_end, advance;

    assign two_r   = {i_radius, 1'b0};
    assign rz      = POS_W'(i_radius);
    assign dx_full = (r_dxi >= rz) ? r_dxi - rz : rz - r_dxi;
    assign dy_full = (r_c >= rz) ? r_c - rz : rz - r_c;
    assign dx2     = dx_full[RAD_W-1:0] * dx_full[RAD_W-1:0];
    assign dy2     = dy_full[RAD_W-1:0] * dy_full[RAD_W-1:0];
    assign dsum    = {1'b0, dx2} + {1'b0, dy2};
    assign in_disc = dsum <= {1'b0, i_bound};

    // Fold the returned pixel into the running extreme
    always_comb begin
        if (i_mode) begin
            ext_acc = (i_rdata < r_ext) ? i_rdata : r_ext;
        end else begin
            ext_acc = (i_rdata > r_ext) ? i_rdata : r_ext;
        end
    end

    assign ext_cur = (r_state == S_ACC) ? ext_acc : r_ext;
    assign lim     = i_mode ? '0 : ALPHA_ONE;
    assign row_end = (r_dxi == two_r);
    assign win_end = (r_c == two_r);

    assign o_busy      = (r_state != S_IDLE);
    assign o_rd_en     = (r_state == S_SCAN) && in_disc;
    assign o_rd_addr   = f_addr(r_slot, r_colb + r_dxi);
    assign o_empty     = !r_out_valid;
    assign o_out_pixel = r_out_pix;
    assign o_tile_done = r_out_last;
    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid && !r_out_valid;

    // Next state: start, read, fold, advance, finish
    always_comb begin
        n_state     = r_state;
        n_c         = r_c;
        n_dxi       = r_dxi;
        n_slot      = r_slot;
        n_colb      = r_colb;
        n_last      = r_last;
        n_ext       = ext_cur;
        n_out_valid = r_out_valid && !i_pop;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;
        advance     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_job_pop) begin
                    n_state = S_SCAN;
                    n_c     = '0;
                    n_dxi   = '0;
                    n_slot  = i_job.slot;
                    n_colb  = i_job.col_base;
                    n_last  = i_job.last;
                    n_ext   = i_mode ? ALPHA_ONE : '0;
                end
            end
            S_SCAN: begin
                if (in_disc) begin
                    n_state = S_ACC;
                end else begin
                    advance = 1'b1;
                end
            end
            S_ACC: begin
                advance = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (advance) begin
            if (row_end && (ext_cur == lim || win_end)) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_out_pix   = ext_cur;
                n_out_last  = r_last;
            end else if (row_end) begin
                n_state = S_SCAN;
                n_dxi   = '0;
                n_c     = r_c + POS_W'(1);
                n_slot  = (r_slot == two_r) ? '0 : r_slot + POS_W'(1);
            end else begin
                n_state = S_SCAN;
                n_dxi   = r_dxi + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_dxi      <= n_dxi;
        r_slot     <= n_slot;
        r_colb     <= n_colb;
        r_last     <= n_last;
        r_ext      <= n_ext;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_SCAN && $past(o_rd_en)))
        else $error("fold without a preceding read");
    a_row_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_c <= two_r && r_dxi <= two_r))
        else $error("scan outside the window");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_pix)))
        else $error("waiting result overwritten");
`endif

endmodule

FILE: hdl/disk_grayscale_dilate_erode_core.sv
// An input that makes no result only writes the row store; one that makes a result is
// also queued as a window job, scanned over the disc and registered at the output.
// One item at a time; the single row store read port walks the window one point per cycle
// for points outside the disc, and reads and then folds each point inside the disc.
// Reset: synchronous active low; radius 1, dilate, position zero; the row store
// is not cleared and is only read where the current tile has written it.
// ---------------------------------------------------------------------------
// disk_grayscale_dilate_erode_core
// Grayscale disc dilation / erosion of one padded tile streamed in raster order.
// ---------------------------------------------------------------------------
module disk_grayscale_dilate_erode_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [15:0]                   i_in_pixel,
    output logic                          empty,
    input  logic                          pop,
    output logic [15:0]                   o_out_pixel,
    output logic                          o_tile_done,
    input  logic                          i_cfg_we,
    input  logic [dge_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [dge_pkg::RAD_W-1:0]     i_cfg_data
);
    import dge_pkg::*;

    logic [RAD_W-1:0]   r_radius, n_radius;
    logic               r_mode;
    logic [BOUND_W-1:0] r_bound, n_bound;
    logic               restart;
    logic               stall;

    t_job             f_job, q_job;
    logic             f_job_push, q_empty, b_job_pop, b_busy;
    logic             mem_we, rd_en;
    logic [ADDR_W-1:0] mem_waddr, rd_addr;
    logic [PIX_W-1:0] mem_wdata, rdata;

    // Clamp the radius and derive the disc bound r*r + r
    always_comb begin
        n_radius = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_radius = RAD_W'(1);
        end else if (i_cfg_data > RAD_W'(MAX_RADIUS)) begin
            n_radius = RAD_W'(MAX_RADIUS);
        end
        n_bound = n_radius * n_radius + BOUND_W'(n_radius);
    end

    assign restart = i_cfg_we && (i_cfg_idx == REG_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_mode   <= 1'b0;
            r_bound  <= BOUND_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RADIUS: begin
                    r_radius <= n_radius;
                    r_bound  <= n_bound;
                end
                REG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold input while a job waits or the window scan runs
    assign stall = !q_empty || b_busy;

    dge_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pixel     (i_in_pixel),
        .i_stall     (stall),
        .i_restart   (restart),
        .i_radius    (r_radius),
        .o_full      (full),
        .o_job_push  (f_job_push),
        .o_job       (f_job),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_waddr),
        .o_mem_wdata (mem_wdata)
    );

    dge_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_job_push),
        .i_job   (f_job),
        .i_pop   (b_job_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    dge_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    dge_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .i_radius    (r_radius),
        .i_mode      (r_mode),
        .i_bound     (r_bound),
        .i_rdata     (rdata),
        .i_pop       (pop),
        .o_job_pop   (b_job_pop),
        .o_busy      (b_busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_empty     (empty),
        .o_out_pixel (o_out_pixel),
        .o_tile_done (o_tile_done)
    );

endmodule
